/* design/jdkm_pkg.sv */
// Shared widths, register codes, key codes and bundle types of the joystick key mapper.
package jdkm_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int THR_SQ_W  = 32;
  localparam int CMP_W     = (SQ_W + 2 > THR_SQ_W) ? SQ_W + 2 : THR_SQ_W;
  localparam int NUM_KEYS  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register codes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_SEQUENCING = 3'd1,
    REG_DIAGONALS  = 3'd2,
    REG_STICKY     = 3'd3,
    REG_SHORT_THR  = 3'd4,
    REG_FAR_THR    = 3'd5,
    REG_SPEED_THR  = 3'd6
  } cfg_reg_t;

  // Squared threshold values after reset (8000, 24000 and 2000)
  localparam logic [THR_SQ_W-1:0] SHORT_SQ_RESET = 32'd64000000;
  localparam logic [THR_SQ_W-1:0] FAR_SQ_RESET   = 32'd576000000;
  localparam logic [THR_SQ_W-1:0] SPEED_SQ_RESET = 32'd4000000;

  // Direction key numbers; up means positive y, right means positive x
  typedef logic [3:0] key_idx_t;
  localparam key_idx_t KEY_UP             = 4'd0;
  localparam key_idx_t KEY_UP_RIGHT       = 4'd1;
  localparam key_idx_t KEY_RIGHT          = 4'd2;
  localparam key_idx_t KEY_DOWN_RIGHT     = 4'd3;
  localparam key_idx_t KEY_DOWN           = 4'd4;
  localparam key_idx_t KEY_DOWN_LEFT      = 4'd5;
  localparam key_idx_t KEY_LEFT           = 4'd6;
  localparam key_idx_t KEY_UP_LEFT        = 4'd7;
  localparam key_idx_t KEY_FAR_UP         = 4'd8;
  localparam key_idx_t KEY_FAR_UP_RIGHT   = 4'd9;
  localparam key_idx_t KEY_FAR_RIGHT      = 4'd10;
  localparam key_idx_t KEY_FAR_DOWN_RIGHT = 4'd11;
  localparam key_idx_t KEY_FAR_DOWN       = 4'd12;
  localparam key_idx_t KEY_FAR_DOWN_LEFT  = 4'd13;
  localparam key_idx_t KEY_FAR_LEFT       = 4'd14;
  localparam key_idx_t KEY_FAR_UP_LEFT    = 4'd15;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic                enable;
    logic                sequencing;
    logic                diagonals;
    logic                sticky_button;
    logic [THR_SQ_W-1:0] short_sq;
    logic [THR_SQ_W-1:0] far_sq;
    logic [THR_SQ_W-1:0] speed_sq;
  } cfg_t;

  // Squares and sign flags of one request, handed to the decision stage
  typedef struct packed {
    logic            vld;
    logic [SQ_W-1:0] x_sq;
    logic [SQ_W-1:0] y_sq;
    logic [SQ_W-1:0] dx_sq;
    logic [SQ_W-1:0] dy_sq;
    logic            x_nz;
    logic            x_neg;
    logic            y_nz;
    logic            y_neg;
    logic            button;
  } sq_item_t;

endpackage

/* design/jdkm_ifs.sv */
// Handshake interfaces of the sample, result and configuration channels.
interface jdkm_in_if;
  import jdkm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic                      button;
  modport source (output valid, output pos_x, output pos_y, output button, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input button, output ready);
endinterface

interface jdkm_out_if;
  import jdkm_pkg::*;
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] direction_keys;
  logic                button_event;
  logic                button_key;
  modport source (output valid, output direction_keys, output button_event,
                  output button_key, input ready);
  modport sink   (input valid, input direction_keys, input button_event,
                  input button_key, output ready);
endinterface

interface jdkm_cfg_if;
  import jdkm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* design/jdkm_cfg_regs.sv */
// Configuration registers; thresholds are kept squared, squared when written.
module jdkm_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  jdkm_cfg_if.sink        cfg_ch,
  output jdkm_pkg::cfg_t  cfg
);
  import jdkm_pkg::*;

  logic                enable_r, sequencing_r, diagonals_r, sticky_r;
  logic [THR_SQ_W-1:0] short_sq_r, far_sq_r, speed_sq_r;
  logic [14:0]         thr15;
  logic [15:0]         thr16;
  logic [THR_SQ_W-1:0] thr15_sq, thr16_sq;

  // Always take writes
  assign cfg_ch.ready = 1'b1;

  // Square the written threshold
  assign thr15    = cfg_ch.wdata[14:0];
  assign thr16    = cfg_ch.wdata[15:0];
  assign thr15_sq = THR_SQ_W'(thr15) * THR_SQ_W'(thr15);
  assign thr16_sq = THR_SQ_W'(thr16) * THR_SQ_W'(thr16);

  // Hold register contents, update on a write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      sequencing_r <= 1'b0;
      diagonals_r  <= 1'b0;
      sticky_r     <= 1'b0;
      short_sq_r   <= SHORT_SQ_RESET;
      far_sq_r     <= FAR_SQ_RESET;
      speed_sq_r   <= SPEED_SQ_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ENABLE:     enable_r     <= cfg_ch.wdata[0];
        REG_SEQUENCING: sequencing_r <= cfg_ch.wdata[0];
        REG_DIAGONALS:  diagonals_r  <= cfg_ch.wdata[0];
        REG_STICKY:     sticky_r     <= cfg_ch.wdata[0];
        REG_SHORT_THR:  short_sq_r   <= thr15_sq;
        REG_FAR_THR:    far_sq_r     <= thr15_sq;
        REG_SPEED_THR:  speed_sq_r   <= thr16_sq;
        default: ;
      endcase
    end
  end

  assign cfg.enable        = enable_r;
  assign cfg.sequencing    = sequencing_r;
  assign cfg.diagonals     = diagonals_r;
  assign cfg.sticky_button = sticky_r;
  assign cfg.short_sq      = short_sq_r;
  assign cfg.far_sq        = far_sq_r;
  assign cfg.speed_sq      = speed_sq_r;

endmodule

/* design/jdkm_front.sv */
// Input register with travel deltas, then the registered squares stage.
module jdkm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic                           enable,
  input  logic                           in_valid,
  input  logic signed [jdkm_pkg::COORD_W-1:0] pos_x,
  input  logic signed [jdkm_pkg::COORD_W-1:0] pos_y,
  input  logic                           button,
  output jdkm_pkg::sq_item_t             sq_o
);
  import jdkm_pkg::*;

  logic                      accept;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic signed [DIFF_W-1:0]  dx_nxt, dy_nxt;
  logic                      s1_vld_r;
  logic signed [COORD_W-1:0] x1_r, y1_r;
  logic signed [DIFF_W-1:0]  dx1_r, dy1_r;
  logic                      btn1_r;
  logic signed [2*COORD_W-1:0] x_prod, y_prod;
  logic signed [2*DIFF_W-1:0]  dx_prod, dy_prod;
  sq_item_t                  sq_nxt, sq_r;

  assign accept = in_valid && advance;

  // Travel since the previous sample
  assign dx_nxt = DIFF_W'(pos_x) - DIFF_W'(prev_x_r);
  assign dy_nxt = DIFF_W'(pos_y) - DIFF_W'(prev_y_r);

  // Record every accepted sample; only enabled ones go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_x_r <= pos_x;
        prev_y_r <= pos_y;
      end
      if (advance) begin
        s1_vld_r <= accept && enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r   <= pos_x;
      y1_r   <= pos_y;
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
      btn1_r <= button;
    end
  end

  // Square position and travel
  assign x_prod  = x1_r * x1_r;
  assign y_prod  = y1_r * y1_r;
  assign dx_prod = dx1_r * dx1_r;
  assign dy_prod = dy1_r * dy1_r;

  always_comb begin
    sq_nxt        = sq_r;
    sq_nxt.vld    = s1_vld_r;
    sq_nxt.x_sq   = x_prod[SQ_W-1:0];
    sq_nxt.y_sq   = y_prod[SQ_W-1:0];
    sq_nxt.dx_sq  = dx_prod[SQ_W-1:0];
    sq_nxt.dy_sq  = dy_prod[SQ_W-1:0];
    sq_nxt.x_nz   = (x1_r != '0);
    sq_nxt.x_neg  = x1_r[COORD_W-1];
    sq_nxt.y_nz   = (y1_r != '0);
    sq_nxt.y_neg  = y1_r[COORD_W-1];
    sq_nxt.button = btn1_r;
  end

  // Advance the squares stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
    end else if (advance) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

/* design/jdkm_decide.sv */
// Speed gate, radius stage, direction keys, button handling and result register.
module jdkm_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  jdkm_pkg::cfg_t                cfg,
  input  jdkm_pkg::sq_item_t            sq,
  output logic                          out_valid,
  output logic [jdkm_pkg::NUM_KEYS-1:0] direction_keys,
  output logic                          button_event,
  output logic                          button_key
);
  import jdkm_pkg::*;

  logic [CMP_W-1:0]    travel_sq, r_sq, x3_sq, y3_sq;
  logic                too_fast, below_short, below_far, active, origin;
  logic                h_on, v_on, far_key;
  logic                make_result;
  logic [NUM_KEYS-1:0] mask_keys, onehot_keys, keys_nxt;
  key_idx_t            h_idx, act_idx;
  logic                act_vld;
  logic                ev_nxt, bk_nxt, prev_btn_nxt, toggle_nxt;
  logic                out_valid_r, ev_r, bk_r, prev_btn_r, toggle_r;
  logic [NUM_KEYS-1:0] keys_r;

  // Speed gate and radius compares
  assign travel_sq   = CMP_W'(sq.dx_sq) + CMP_W'(sq.dy_sq);
  assign too_fast    = travel_sq > CMP_W'(cfg.speed_sq);
  assign r_sq        = CMP_W'(sq.x_sq) + CMP_W'(sq.y_sq);
  assign below_short = r_sq < CMP_W'(cfg.short_sq);
  assign below_far   = r_sq < CMP_W'(cfg.far_sq);
  assign active      = !below_short;
  assign far_key     = cfg.sequencing && !below_far;

  // Sector tests: 3*a^2 >= b^2
  assign x3_sq  = (CMP_W'(sq.x_sq) << 1) + CMP_W'(sq.x_sq);
  assign y3_sq  = (CMP_W'(sq.y_sq) << 1) + CMP_W'(sq.y_sq);
  assign origin = !sq.x_nz && !sq.y_nz;
  assign v_on   = active && sq.y_nz && (y3_sq >= CMP_W'(sq.x_sq));
  assign h_on   = active && (origin || (sq.x_nz && (x3_sq >= CMP_W'(sq.y_sq))));

  // Horizontal key; the origin points right since its sign bit is clear
  always_comb begin
    if (sq.x_neg) begin
      h_idx = far_key ? KEY_FAR_LEFT : KEY_LEFT;
    end else begin
      h_idx = far_key ? KEY_FAR_RIGHT : KEY_RIGHT;
    end
  end

  // Combinable mask: one horizontal and one vertical key
  always_comb begin
    mask_keys = '0;
    if (h_on) begin
      mask_keys[h_idx] = 1'b1;
    end
    if (v_on) begin
      if (sq.y_neg) begin
        mask_keys[far_key ? KEY_FAR_DOWN : KEY_DOWN] = 1'b1;
      end else begin
        mask_keys[far_key ? KEY_FAR_UP : KEY_UP] = 1'b1;
      end
    end
  end

  // One-hot action: vertical folds into the horizontal key
  always_comb begin
    act_vld = h_on;
    act_idx = h_idx;
    if (v_on) begin
      act_vld = 1'b1;
      if (!sq.y_neg) begin
        if (far_key) begin
          act_idx = !h_on ? KEY_FAR_UP
                  : (h_idx == KEY_FAR_RIGHT) ? KEY_FAR_UP_RIGHT
                  : (h_idx == KEY_FAR_LEFT) ? KEY_FAR_UP_LEFT : KEY_FAR_UP;
        end else begin
          act_idx = !h_on ? KEY_UP
                  : (h_idx == KEY_RIGHT) ? KEY_UP_RIGHT
                  : (h_idx == KEY_LEFT) ? KEY_UP_LEFT : KEY_UP;
        end
      end else begin
        if (far_key) begin
          act_idx = !h_on ? KEY_FAR_DOWN
                  : (h_idx == KEY_FAR_RIGHT) ? KEY_FAR_DOWN_RIGHT
                  : (h_idx == KEY_FAR_LEFT) ? KEY_FAR_DOWN_LEFT : KEY_FAR_DOWN;
        end else begin
          act_idx = !h_on ? KEY_DOWN
                  : (h_idx == KEY_RIGHT) ? KEY_DOWN_RIGHT
                  : (h_idx == KEY_LEFT) ? KEY_DOWN_LEFT : KEY_DOWN;
        end
      end
    end
    onehot_keys = act_vld ? (NUM_KEYS'(1) << act_idx) : '0;
  end

  assign keys_nxt    = cfg.diagonals ? mask_keys : onehot_keys;
  assign make_result = sq.vld && !too_fast;

  // Button edge handling, normal or sticky toggle
  always_comb begin
    ev_nxt       = 1'b0;
    bk_nxt       = 1'b0;
    prev_btn_nxt = prev_btn_r;
    toggle_nxt   = toggle_r;
    if (make_result && (prev_btn_r != sq.button)) begin
      prev_btn_nxt = sq.button;
      if (!cfg.sticky_button) begin
        ev_nxt = 1'b1;
        bk_nxt = sq.button;
      end else if (sq.button) begin
        toggle_nxt = !toggle_r;
        ev_nxt     = 1'b1;
        bk_nxt     = !toggle_r;
      end
    end
  end

  // Hold button state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_btn_r  <= 1'b0;
      toggle_r    <= 1'b0;
    end else if (advance) begin
      out_valid_r <= make_result;
      prev_btn_r  <= prev_btn_nxt;
      toggle_r    <= toggle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keys_r <= keys_nxt;
      ev_r   <= ev_nxt;
      bk_r   <= bk_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign direction_keys = keys_r;
  assign button_event   = ev_r;
  assign button_key     = bk_r;

  // One-hot mode never presses two keys
  a_onehot_keys: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cfg.diagonals |-> $onehot0(keys_r))
    else $error("one-hot mode produced several keys");

  // Key state is only set together with a button event
  a_key_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !ev_r |-> !bk_r)
    else $error("button key set without event");

  // No result without a request in the squares stage
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !sq.vld |=> !out_valid_r)
    else $error("result without request");

  // Toggle flips only on a sticky press
  a_toggle_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(toggle_r) |->
      $past(cfg.sticky_button && make_result && advance))
    else $error("toggle changed without sticky press");

  // Sticky events report the toggle state
  a_sticky_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_r && cfg.sticky_button |-> bk_r == toggle_r)
    else $error("sticky event does not match toggle");

endmodule

/* design/joystick_direction_key_mapper.sv */
// Top level of the joystick direction key mapper.
// Takes one joystick sample per clock and turns it into direction key and button
// key states. An accepted sample is taken into an input register (position and travel
// deltas), moves on to a squares register, and then to the result register behind the
// compares and key mapping, where its result is valid. Throughput is one sample per
// cycle; the whole pipe stalls only while a finished result waits on out_ch.ready,
// and in_ch.ready follows that. Samples taken while disabled, and
// samples that moved farther than the speed threshold, update the stored position
// but give no result. Configuration writes are taken in any cycle and should only be
// made while no sample is in flight; there is no start-up pass after reset.
module joystick_direction_key_mapper (
  input  logic        clk,
  input  logic        rst_n,
  jdkm_in_if.sink     in_ch,
  jdkm_out_if.source  out_ch,
  jdkm_cfg_if.sink    cfg_ch
);
  import jdkm_pkg::*;

  cfg_t     cfg;
  sq_item_t sq;
  logic     advance;
  logic     out_valid;

  // Move the pipe when the result register is free or being taken
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance;

  jdkm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  jdkm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .enable   (cfg.enable),
    .in_valid (in_ch.valid),
    .pos_x    (in_ch.pos_x),
    .pos_y    (in_ch.pos_y),
    .button   (in_ch.button),
    .sq_o     (sq)
  );

  jdkm_decide u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .cfg            (cfg),
    .sq             (sq),
    .out_valid      (out_valid),
    .direction_keys (out_ch.direction_keys),
    .button_event   (out_ch.button_event),
    .button_key     (out_ch.button_key)
  );

  assign out_ch.valid = out_valid;

endmodule
